// File: design/go_to_goal_pi_controller_top_assert.svh
// assertion macros for the go-to-goal controller
`ifndef GO_TO_GOAL_PI_CONTROLLER_TOP_ASSERT_SVH
`define GO_TO_GOAL_PI_CONTROLLER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define G2G_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("g2gpi assertion failed");
`define G2G_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("g2gpi assertion failed");
`else
`define G2G_ASSERT(lbl, prop)
`define G2G_ASSERT_NR(lbl, prop)
`endif
`endif

// File: design/g2gpi_pkg.sv
package g2gpi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CW  = 45;
    localparam int ZW  = 20;
    localparam int MAW = 34;
    localparam int MBW = 25;
    localparam int MPW = MAW + MBW;
    localparam int LW  = 60;

    localparam logic signed [ZW-1:0] HALF_PI   = 20'sd102944;
    localparam logic signed [17:0]   ONE_Q     = 18'sd65536;
    localparam logic [16:0]          HALF_M    = 17'd32768;
    localparam logic [47:0]          INTEG_MAX = 48'h7FFF_FFFF_FFFF;

    localparam logic signed [31:0] GOAL_RST    = 32'sd0;
    localparam logic signed [23:0] KP_DIST_RST = 24'sd131072;
    localparam logic signed [23:0] KI_DIST_RST = 24'sd0;
    localparam logic signed [23:0] KP_HEAD_RST = 24'sd32768;
    localparam logic [30:0]        STOP_RST    = 31'd6554;

    typedef enum logic [2:0] {
        REG_GOAL_X,
        REG_GOAL_Y,
        REG_KP_DIST,
        REG_KI_DIST,
        REG_KP_HEAD,
        REG_STOP
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [23:0] kp_dist;
        logic signed [23:0] ki_dist;
        logic signed [23:0] kp_head;
        logic [30:0]        stop_thr;
    } t_cfg;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_QXY,
        MS_QWZ,
        MS_QWW,
        MS_QXX,
        MS_QYY,
        MS_QZZ,
        MS_DXX,
        MS_DYY,
        MS_DIST_DT,
        MS_KP_DIST,
        MS_KI_IH,
        MS_KI_IL,
        MS_KP_EA
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QMUL,
        ST_SQMUL,
        ST_CRD_LOAD,
        ST_CRD_NORM,
        ST_CRD_QUAD,
        ST_CRD_ITER,
        ST_CRD_SAVE,
        ST_SQ_LOAD,
        ST_SQ_ITER,
        ST_OUT_MUL,
        ST_TAIL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        t_mul_sel   mul;
        logic       crd_load;
        logic       crd_bearing;
        logic       crd_norm;
        logic       crd_quad;
        logic       crd_iter;
        logic       crd_save;
        logic       sq_load;
        logic       sq_iter;
        logic [4:0] step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic crd_norm_done;
        logic out_free;
    } t_status;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30386;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: design/g2gpi_ctrl.sv
module g2gpi_ctrl #(
    parameter int CORDIC_STEPS = g2gpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output g2gpi_pkg::t_cmd     o_cmd,
    input  g2gpi_pkg::t_status  i_status
);

    localparam int CNTW = ($clog2(CORDIC_STEPS) > 4) ? $clog2(CORDIC_STEPS) : 4;
    localparam logic [CNTW-1:0] CRD_LAST  = CNTW'(CORDIC_STEPS - 1);
    localparam logic [CNTW-1:0] SQ_LAST   = CNTW'(15);
    localparam logic [CNTW-1:0] QMUL_LAST = CNTW'(5);
    localparam logic [CNTW-1:0] SQM_LAST  = CNTW'(1);
    localparam logic [CNTW-1:0] OMUL_LAST = CNTW'(4);

    g2gpi_pkg::t_state r_state, n_state;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic              r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= g2gpi_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_cnt             = r_cnt;
        n_pass            = r_pass;
        o_cmd             = '0;
        o_cmd.mul         = g2gpi_pkg::MS_NONE;
        o_cmd.step        = 5'(r_cnt);
        o_cmd.crd_bearing = r_pass;
        unique case (r_state)
            g2gpi_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = g2gpi_pkg::ST_QMUL;
                end
            end
            g2gpi_pkg::ST_QMUL: begin
                case (r_cnt)
                    CNTW'(0): o_cmd.mul = g2gpi_pkg::MS_QXY;
                    CNTW'(1): o_cmd.mul = g2gpi_pkg::MS_QWZ;
                    CNTW'(2): o_cmd.mul = g2gpi_pkg::MS_QWW;
                    CNTW'(3): o_cmd.mul = g2gpi_pkg::MS_QXX;
                    CNTW'(4): o_cmd.mul = g2gpi_pkg::MS_QYY;
                    default:  o_cmd.mul = g2gpi_pkg::MS_QZZ;
                endcase
                if (r_cnt == QMUL_LAST) begin
                    n_cnt   = '0;
                    n_state = g2gpi_pkg::ST_SQMUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            g2gpi_pkg::ST_SQMUL: begin
                o_cmd.mul = (r_cnt == SQM_LAST) ? g2gpi_pkg::MS_DYY : g2gpi_pkg::MS_DXX;
                if (r_cnt == SQM_LAST) begin
                    n_cnt   = '0;
                    n_pass  = 1'b0;
                    n_state = g2gpi_pkg::ST_CRD_LOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            g2gpi_pkg::ST_CRD_LOAD: begin
                o_cmd.crd_load = 1'b1;
                n_state        = g2gpi_pkg::ST_CRD_NORM;
            end
            g2gpi_pkg::ST_CRD_NORM: begin
                o_cmd.crd_norm = 1'b1;
                if (i_status.crd_norm_done) begin
                    n_state = g2gpi_pkg::ST_CRD_QUAD;
                end
            end
            g2gpi_pkg::ST_CRD_QUAD: begin
                o_cmd.crd_quad = 1'b1;
                n_cnt          = '0;
                n_state        = g2gpi_pkg::ST_CRD_ITER;
            end
            g2gpi_pkg::ST_CRD_ITER: begin
                o_cmd.crd_iter = 1'b1;
                if (r_cnt == CRD_LAST) begin
                    n_cnt   = '0;
                    n_state = g2gpi_pkg::ST_CRD_SAVE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            g2gpi_pkg::ST_CRD_SAVE: begin
                o_cmd.crd_save = 1'b1;
                if (r_pass) begin
                    n_state = g2gpi_pkg::ST_SQ_LOAD;
                end else begin
                    n_pass  = 1'b1;
                    n_state = g2gpi_pkg::ST_CRD_LOAD;
                end
            end
            g2gpi_pkg::ST_SQ_LOAD: begin
                o_cmd.sq_load = 1'b1;
                n_cnt         = '0;
                n_state       = g2gpi_pkg::ST_SQ_ITER;
            end
            g2gpi_pkg::ST_SQ_ITER: begin
                o_cmd.sq_iter = 1'b1;
                if (r_cnt == SQ_LAST) begin
                    n_cnt   = '0;
                    n_state = g2gpi_pkg::ST_OUT_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            g2gpi_pkg::ST_OUT_MUL: begin
                case (r_cnt)
                    CNTW'(0): o_cmd.mul = g2gpi_pkg::MS_DIST_DT;
                    CNTW'(1): o_cmd.mul = g2gpi_pkg::MS_KP_DIST;
                    CNTW'(2): o_cmd.mul = g2gpi_pkg::MS_KI_IH;
                    CNTW'(3): o_cmd.mul = g2gpi_pkg::MS_KI_IL;
                    default:  o_cmd.mul = g2gpi_pkg::MS_KP_EA;
                endcase
                if (r_cnt == OMUL_LAST) begin
                    n_cnt   = '0;
                    n_state = g2gpi_pkg::ST_TAIL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            g2gpi_pkg::ST_TAIL: begin
                n_state = g2gpi_pkg::ST_OUT;
            end
            g2gpi_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = g2gpi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = g2gpi_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == g2gpi_pkg::ST_IDLE);

endmodule

// File: design/g2gpi_dpath.sv
`include "go_to_goal_pi_controller_top_assert.svh"

module g2gpi_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  g2gpi_pkg::t_cfg           i_cfg,
    input  g2gpi_pkg::t_cmd           i_cmd,
    output g2gpi_pkg::t_status        o_status,
    input  logic signed [31:0]        i_pos_x,
    input  logic signed [31:0]        i_pos_y,
    input  logic signed [15:0]        i_quat_x,
    input  logic signed [15:0]        i_quat_y,
    input  logic signed [15:0]        i_quat_z,
    input  logic signed [15:0]        i_quat_w,
    input  logic [31:0]               i_timestamp,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic signed [31:0]        o_linear_velocity,
    output logic signed [31:0]        o_angular_velocity,
    output logic                      o_goal_reached
);

    localparam int CW  = g2gpi_pkg::CW;
    localparam int ZW  = g2gpi_pkg::ZW;
    localparam int MAW = g2gpi_pkg::MAW;
    localparam int MBW = g2gpi_pkg::MBW;
    localparam int MPW = g2gpi_pkg::MPW;
    localparam int LW  = g2gpi_pkg::LW;
    localparam logic [CW-1:0] LIM40 = CW'(1) << 40;
    localparam logic [CW-1:0] LIM32 = CW'(1) << 32;
    localparam logic signed [LW-1:0] LIN_MAX = LW'(32'sh7FFF_FFFF);
    localparam logic signed [LW-1:0] LIN_MIN = LW'(-33'sh8000_0000);
    localparam logic signed [42:0]   ANG_MAX = 43'(32'sh7FFF_FFFF);
    localparam logic signed [42:0]   ANG_MIN = 43'(-33'sh8000_0000);

    logic signed [32:0]     r_dx, r_dy;
    logic signed [15:0]     r_qx, r_qy, r_qz, r_qw;
    logic [31:0]            r_dt, r_prev;
    logic                   r_started;

    logic signed [MAW-1:0]  w_a;
    logic signed [MBW-1:0]  w_b;
    logic signed [MPW-1:0]  w_prod, r_prod;
    g2gpi_pkg::t_mul_sel    r_tag;

    logic signed [33:0]     r_ax, r_ay;
    logic [31:0]            r_sq;
    logic [47:0]            r_integ;
    logic [48:0]            w_integ_sum;
    logic signed [LW-1:0]   r_lin;
    logic signed [42:0]     r_ang;

    logic signed [CW-1:0]   r_crx, r_cry;
    logic signed [ZW-1:0]   r_z, r_yaw, r_brg;
    logic                   r_czero;
    logic signed [CW-1:0]   w_ldx, w_ldy, w_xs, w_ys;
    logic [CW-1:0]          w_mx, w_my;
    logic                   w_small40, w_small32;

    logic signed [20:0]     w_diff;
    logic signed [17:0]     w_ea;

    logic [31:0]            r_sv, r_sr, w_bit;
    logic [4:0]             w_sh;
    logic [32:0]            w_rb;
    logic [32:0]            w_dxm, w_dym;
    logic                   w_far;
    logic [16:0]            w_dist;

    logic signed [31:0]     w_lin_sat, w_ang_sat;
    logic [32:0]            w_lin_ext, w_lin_mag;
    logic                   w_reached;

    logic                   r_out_valid, r_out_reached;
    logic signed [31:0]     r_out_lin, r_out_ang;

    // input capture and elapsed time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_started <= 1'b0;
        end else if (i_cmd.load) begin
            r_prev    <= i_timestamp;
            r_started <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx <= 33'(i_cfg.goal_x) - 33'(i_pos_x);
            r_dy <= 33'(i_cfg.goal_y) - 33'(i_pos_y);
            r_qx <= i_quat_x;
            r_qy <= i_quat_y;
            r_qz <= i_quat_z;
            r_qw <= i_quat_w;
            r_dt <= r_started ? (i_timestamp - r_prev) : 32'd0;
        end
    end

    // shared multiplier operand select
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.mul)
            g2gpi_pkg::MS_QXY: begin
                w_a = MAW'(r_qx);
                w_b = MBW'(r_qy);
            end
            g2gpi_pkg::MS_QWZ: begin
                w_a = MAW'(r_qw);
                w_b = MBW'(r_qz);
            end
            g2gpi_pkg::MS_QWW: begin
                w_a = MAW'(r_qw);
                w_b = MBW'(r_qw);
            end
            g2gpi_pkg::MS_QXX: begin
                w_a = MAW'(r_qx);
                w_b = MBW'(r_qx);
            end
            g2gpi_pkg::MS_QYY: begin
                w_a = MAW'(r_qy);
                w_b = MBW'(r_qy);
            end
            g2gpi_pkg::MS_QZZ: begin
                w_a = MAW'(r_qz);
                w_b = MBW'(r_qz);
            end
            g2gpi_pkg::MS_DXX: begin
                w_a = MAW'(r_dx);
                w_b = MBW'(r_dx);
            end
            g2gpi_pkg::MS_DYY: begin
                w_a = MAW'(r_dy);
                w_b = MBW'(r_dy);
            end
            g2gpi_pkg::MS_DIST_DT: begin
                w_a = {2'b00, r_dt};
                w_b = {8'd0, w_dist};
            end
            g2gpi_pkg::MS_KP_DIST: begin
                w_a = {17'd0, w_dist};
                w_b = MBW'(i_cfg.kp_dist);
            end
            g2gpi_pkg::MS_KI_IH: begin
                w_a = {2'b00, r_integ[47:16]};
                w_b = MBW'(i_cfg.ki_dist);
            end
            g2gpi_pkg::MS_KI_IL: begin
                w_a = {18'd0, r_integ[15:0]};
                w_b = MBW'(i_cfg.ki_dist);
            end
            g2gpi_pkg::MS_KP_EA: begin
                w_a = MAW'(w_ea);
                w_b = MBW'(i_cfg.kp_head);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= g2gpi_pkg::MS_NONE;
        end else begin
            r_tag <= i_cmd.mul;
        end
        r_prod <= w_prod;
    end

    // accumulate from the registered multiplier product and tag
    assign w_integ_sum = {1'b0, r_integ} + 49'(r_prod[MPW-1:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (r_tag == g2gpi_pkg::MS_DIST_DT) begin
            r_integ <= (w_integ_sum > {1'b0, g2gpi_pkg::INTEG_MAX}) ?
                       g2gpi_pkg::INTEG_MAX : w_integ_sum[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_tag)
            g2gpi_pkg::MS_QXY:     r_ay  <= r_prod[33:0];
            g2gpi_pkg::MS_QWZ:     r_ay  <= r_ay + r_prod[33:0];
            g2gpi_pkg::MS_QWW:     r_ax  <= r_prod[33:0];
            g2gpi_pkg::MS_QXX:     r_ax  <= r_ax + r_prod[33:0];
            g2gpi_pkg::MS_QYY:     r_ax  <= r_ax - r_prod[33:0];
            g2gpi_pkg::MS_QZZ:     r_ax  <= r_ax - r_prod[33:0];
            g2gpi_pkg::MS_DXX:     r_sq  <= r_prod[31:0];
            g2gpi_pkg::MS_DYY:     r_sq  <= r_sq + r_prod[31:0];
            g2gpi_pkg::MS_KP_DIST: r_lin <= LW'($signed(r_prod[MPW-1:16]));
            g2gpi_pkg::MS_KI_IH:   r_lin <= r_lin + LW'(r_prod);
            g2gpi_pkg::MS_KI_IL:   r_lin <= r_lin + LW'($signed(r_prod[MPW-1:16]));
            g2gpi_pkg::MS_KP_EA:   r_ang <= $signed(r_prod[MPW-1:16]);
            default: begin
            end
        endcase
    end

    // cordic vectoring
    assign w_ldx = i_cmd.crd_bearing ? CW'(r_dx) : CW'(r_ax);
    assign w_ldy = i_cmd.crd_bearing ? CW'(r_dy) : CW'($signed({r_ay, 1'b0}));
    assign w_mx  = r_crx[CW-1] ? 45'(-r_crx) : r_crx;
    assign w_my  = r_cry[CW-1] ? 45'(-r_cry) : r_cry;
    assign w_small40 = (w_mx < LIM40) && (w_my < LIM40);
    assign w_small32 = (w_mx < LIM32) && (w_my < LIM32);
    assign w_xs = r_crx >>> i_cmd.step;
    assign w_ys = r_cry >>> i_cmd.step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.crd_load) begin
            r_crx   <= w_ldx;
            r_cry   <= w_ldy;
            r_czero <= (w_ldx == '0) && (w_ldy == '0);
        end else if (i_cmd.crd_norm) begin
            if (!r_czero && w_small32) begin
                r_crx <= r_crx <<< 8;
                r_cry <= r_cry <<< 8;
            end else if (!r_czero && w_small40) begin
                r_crx <= r_crx <<< 1;
                r_cry <= r_cry <<< 1;
            end
        end else if (i_cmd.crd_quad) begin
            if (r_crx < 0) begin
                if (r_cry >= 0) begin
                    r_crx <= r_cry;
                    r_cry <= -r_crx;
                    r_z   <= g2gpi_pkg::HALF_PI;
                end else begin
                    r_crx <= -r_cry;
                    r_cry <= r_crx;
                    r_z   <= -g2gpi_pkg::HALF_PI;
                end
            end else begin
                r_z <= '0;
            end
        end else if (i_cmd.crd_iter) begin
            if (r_cry >= 0) begin
                r_crx <= r_crx + w_ys;
                r_cry <= r_cry - w_xs;
                r_z   <= r_z + g2gpi_pkg::atan_q16(i_cmd.step);
            end else begin
                r_crx <= r_crx - w_ys;
                r_cry <= r_cry + w_xs;
                r_z   <= r_z - g2gpi_pkg::atan_q16(i_cmd.step);
            end
        end
        if (i_cmd.crd_save) begin
            if (i_cmd.crd_bearing) begin
                r_brg <= r_czero ? '0 : r_z;
            end else begin
                r_yaw <= r_czero ? '0 : r_z;
            end
        end
    end

    // heading error clamp
    assign w_diff = 21'(r_brg) - 21'(r_yaw);
    always_comb begin
        if (w_diff > 21'(g2gpi_pkg::ONE_Q)) begin
            w_ea = g2gpi_pkg::ONE_Q;
        end else if (w_diff < -21'(g2gpi_pkg::ONE_Q)) begin
            w_ea = -g2gpi_pkg::ONE_Q;
        end else begin
            w_ea = 18'(w_diff);
        end
    end

    // integer square root, two bits a beat
    assign w_sh  = 5'd30 - {i_cmd.step[3:0], 1'b0};
    assign w_bit = 32'd1 << w_sh;
    assign w_rb  = {1'b0, r_sr} + {1'b0, w_bit};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            r_sv <= r_sq;
            r_sr <= '0;
        end else if (i_cmd.sq_iter) begin
            if ({1'b0, r_sv} >= w_rb) begin
                r_sv <= r_sv - w_rb[31:0];
                r_sr <= (r_sr >> 1) + w_bit;
            end else begin
                r_sr <= r_sr >> 1;
            end
        end
    end

    assign w_dxm  = r_dx[32] ? 33'(-r_dx) : r_dx;
    assign w_dym  = r_dy[32] ? 33'(-r_dy) : r_dy;
    assign w_far  = (w_dxm >= 33'(g2gpi_pkg::HALF_M)) || (w_dym >= 33'(g2gpi_pkg::HALF_M));
    assign w_dist = (w_far || (r_sr > 32'(g2gpi_pkg::HALF_M))) ? g2gpi_pkg::HALF_M : r_sr[16:0];

    // saturation and stop test
    assign w_lin_sat = (r_lin > LIN_MAX) ? 32'sh7FFF_FFFF :
                       (r_lin < LIN_MIN) ? 32'sh8000_0000 : r_lin[31:0];
    assign w_ang_sat = (r_ang > ANG_MAX) ? 32'sh7FFF_FFFF :
                       (r_ang < ANG_MIN) ? 32'sh8000_0000 : r_ang[31:0];
    assign w_lin_ext = {w_lin_sat[31], w_lin_sat};
    assign w_lin_mag = w_lin_sat[31] ? (33'd0 - w_lin_ext) : w_lin_ext;
    assign w_reached = !(w_lin_mag > {2'b00, i_cfg.stop_thr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_lin     <= w_reached ? 32'sd0 : w_lin_sat;
            r_out_ang     <= w_reached ? 32'sd0 : w_ang_sat;
            r_out_reached <= w_reached;
        end
    end

    assign o_status.crd_norm_done = r_czero || !w_small40;
    assign o_status.out_free      = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_linear_velocity  = r_out_lin;
    assign o_angular_velocity = r_out_ang;
    assign o_goal_reached     = r_out_reached;

    `G2G_ASSERT(a_reach_zero, r_out_valid && r_out_reached |-> r_out_lin == '0 && r_out_ang == '0)
    `G2G_ASSERT(a_integ_pos, !r_integ[47])
    `G2G_ASSERT(a_start_after_load, i_cmd.load |=> r_started)
    `G2G_ASSERT(a_load_when_free, i_cmd.out_load |-> !r_out_valid || i_out_ready)

endmodule

// File: design/go_to_goal_pi_controller_top.sv
// channel   dir  handshake                  payload
// odometry  in   i_in_valid / o_in_ready    pos_x, pos_y, quat_x..w, timestamp
// command   out  o_out_valid / i_out_ready  linear_velocity, angular_velocity, goal_reached
// config    in   apb psel/penable/pwrite    paddr, pwdata, prdata
//
// one odometry beat in flight; a new beat is taken only after the last result is loaded for output
// reset is synchronous, active low, clears control, integrator and output state and restores register defaults
// a finished result waits in the output register while the next beat is taken
module go_to_goal_pi_controller_top #(
    parameter int CORDIC_STEPS = g2gpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  logic [31:0]        i_timestamp,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_linear_velocity,
    output logic signed [31:0] o_angular_velocity,
    output logic               o_goal_reached
);

    g2gpi_pkg::t_cfg     r_cfg;
    g2gpi_pkg::t_cmd     w_cmd;
    g2gpi_pkg::t_status  w_status;
    g2gpi_pkg::t_reg_idx w_idx;

    assign w_idx  = g2gpi_pkg::t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_x   <= g2gpi_pkg::GOAL_RST;
            r_cfg.goal_y   <= g2gpi_pkg::GOAL_RST;
            r_cfg.kp_dist  <= g2gpi_pkg::KP_DIST_RST;
            r_cfg.ki_dist  <= g2gpi_pkg::KI_DIST_RST;
            r_cfg.kp_head  <= g2gpi_pkg::KP_HEAD_RST;
            r_cfg.stop_thr <= g2gpi_pkg::STOP_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                g2gpi_pkg::REG_GOAL_X:  r_cfg.goal_x   <= pwdata;
                g2gpi_pkg::REG_GOAL_Y:  r_cfg.goal_y   <= pwdata;
                g2gpi_pkg::REG_KP_DIST: r_cfg.kp_dist  <= pwdata[23:0];
                g2gpi_pkg::REG_KI_DIST: r_cfg.ki_dist  <= pwdata[23:0];
                g2gpi_pkg::REG_KP_HEAD: r_cfg.kp_head  <= pwdata[23:0];
                g2gpi_pkg::REG_STOP:    r_cfg.stop_thr <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            g2gpi_pkg::REG_GOAL_X:  prdata = r_cfg.goal_x;
            g2gpi_pkg::REG_GOAL_Y:  prdata = r_cfg.goal_y;
            g2gpi_pkg::REG_KP_DIST: prdata = 32'(r_cfg.kp_dist);
            g2gpi_pkg::REG_KI_DIST: prdata = 32'(r_cfg.ki_dist);
            g2gpi_pkg::REG_KP_HEAD: prdata = 32'(r_cfg.kp_head);
            g2gpi_pkg::REG_STOP:    prdata = {1'b0, r_cfg.stop_thr};
            default:                prdata = '0;
        endcase
    end

    g2gpi_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    g2gpi_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_quat_x           (i_quat_x),
        .i_quat_y           (i_quat_y),
        .i_quat_z           (i_quat_z),
        .i_quat_w           (i_quat_w),
        .i_timestamp        (i_timestamp),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_linear_velocity  (o_linear_velocity),
        .o_angular_velocity (o_angular_velocity),
        .o_goal_reached     (o_goal_reached)
    );

endmodule
